@@ sv/asq_pkg.sv @@
// Shared types, codes and constants for the ATA taskfile address sequencer.
package asq_pkg;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_ADVANCE = 1'b1;

  localparam logic       CFG_HEADS  = 1'b0;
  localparam logic       CFG_SPT    = 1'b1;

  localparam logic [4:0] HEADS_RESET = 5'd16;
  localparam logic [7:0] SPT_RESET   = 8'd63;
  localparam logic [8:0] COUNT_FULL  = 9'h100;
  localparam int unsigned DH_LBA_BIT = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ADV,
    S_DONE
  } asq_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] sector_count_in;
    logic [7:0] sector_number_in;
    logic [7:0] cylinder_low_in;
    logic [7:0] cylinder_high_in;
    logic [7:0] device_head_in;
  } asq_in_t;

  typedef struct packed {
    logic [27:0] block_address;
    logic [7:0]  sector_number_out;
    logic [7:0]  cylinder_low_out;
    logic [7:0]  cylinder_high_out;
    logic [7:0]  device_head_out;
    logic [8:0]  sectors_left;
    logic        overrun;
  } asq_out_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic step;
    logic refuse;
    logic out_load;
  } asq_cmd_t;

  typedef struct packed {
    logic last_sector;
  } asq_status_t;

endpackage

@@ sv/asq_ctrl.sv @@
// Controller state machine of the ATA taskfile address sequencer.
module asq_ctrl
  import asq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        op_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  asq_status_t status_i,
  output asq_cmd_t    cmd_o
);

  asq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == OP_ADVANCE) ? S_ADV : S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_DONE;
      S_ADV:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i && (op_i == OP_LOAD);
      end
      S_MUL1: cmd_o.mul1 = 1'b1;
      S_MUL2: cmd_o.mul2 = 1'b1;
      S_ADV: begin
        cmd_o.step   = !status_i.last_sector;
        cmd_o.refuse = status_i.last_sector;
      end
      S_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || !out_stall_i)
    else $error("output register overwritten while stalled");

  // The address product takes both multiply steps in order.
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL1 |=> state_q == S_MUL2)
    else $error("multiply steps out of order");

endmodule

@@ sv/asq_dp.sv @@
// Datapath of the ATA taskfile address sequencer: geometry, position state and output register.
module asq_dp
  import asq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  asq_in_t     in_data_i,
  input  asq_cmd_t    cmd_i,
  output asq_status_t status_o,
  output asq_out_t    out_data_o
);

  logic [4:0]  heads_q;
  logic [7:0]  spt_q;
  logic [15:0] sector_q, sector_d;
  logic [15:0] cyl_q, cyl_d;
  logic [7:0]  head_q, head_d;
  logic [27:0] lba_q, lba_d;
  logic        lba_sel_q, lba_sel_d;
  logic [3:0]  drive_q, drive_d;
  logic [8:0]  remaining_q, remaining_d;
  logic        overrun_q, overrun_d;
  logic [21:0] prod1_q;
  logic [21:0] prod1_d;
  logic [29:0] prod2;
  logic [27:0] lba_chs;
  logic [7:0]  head_inc;
  asq_out_t    out_q, out_d;

  assign status_o.last_sector = (remaining_q <= 9'd1);

  // Cylinder times heads plus head, then times sectors plus sector minus one.
  assign prod1_d  = ({6'b0, cyl_q} * {17'b0, heads_q}) + {14'b0, head_q};
  assign prod2    = {8'b0, prod1_q} * {22'b0, spt_q};
  assign lba_chs  = prod2[27:0] + {12'b0, sector_q} - 28'd1;
  assign head_inc = head_q + 8'd1;

  always_comb begin
    sector_d    = sector_q;
    cyl_d       = cyl_q;
    head_d      = head_q;
    lba_d       = lba_q;
    lba_sel_d   = lba_sel_q;
    drive_d     = drive_q;
    remaining_d = remaining_q;
    overrun_d   = overrun_q;
    if (cmd_i.load) begin
      sector_d    = {8'b0, in_data_i.sector_number_in};
      cyl_d       = {in_data_i.cylinder_high_in, in_data_i.cylinder_low_in};
      head_d      = {4'b0, in_data_i.device_head_in[3:0]};
      lba_sel_d   = in_data_i.device_head_in[DH_LBA_BIT];
      drive_d     = in_data_i.device_head_in[7:4];
      remaining_d = (in_data_i.sector_count_in == 8'd0) ? COUNT_FULL
                                                         : {1'b0, in_data_i.sector_count_in};
      overrun_d   = 1'b0;
    end
    if (cmd_i.mul2) begin
      lba_d = lba_sel_q ? {head_q[3:0], cyl_q, sector_q[7:0]} : lba_chs;
    end
    if (cmd_i.refuse) begin
      overrun_d = 1'b1;
    end
    if (cmd_i.step) begin
      overrun_d   = 1'b0;
      remaining_d = remaining_q - 9'd1;
      lba_d       = lba_q + 28'd1;
      if (sector_q == {8'b0, spt_q}) begin
        sector_d = 16'd1;
        if (head_inc == {3'b0, heads_q}) begin
          head_d = 8'd0;
          cyl_d  = cyl_q + 16'd1;
        end else begin
          head_d = head_inc;
        end
      end else begin
        sector_d = sector_q + 16'd1;
      end
    end
  end

  always_comb begin
    out_d               = out_q;
    out_d.block_address = lba_q;
    if (lba_sel_q) begin
      out_d.sector_number_out = lba_q[7:0];
      out_d.cylinder_low_out  = lba_q[15:8];
      out_d.cylinder_high_out = lba_q[23:16];
      out_d.device_head_out   = {drive_q, lba_q[27:24]};
    end else begin
      out_d.sector_number_out = sector_q[7:0];
      out_d.cylinder_low_out  = cyl_q[7:0];
      out_d.cylinder_high_out = cyl_q[15:8];
      out_d.device_head_out   = {drive_q, head_q[3:0]};
    end
    out_d.sectors_left = remaining_q;
    out_d.overrun      = overrun_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_q     <= HEADS_RESET;
      spt_q       <= SPT_RESET;
      sector_q    <= '0;
      cyl_q       <= '0;
      head_q      <= '0;
      lba_q       <= '0;
      lba_sel_q   <= 1'b0;
      drive_q     <= '0;
      remaining_q <= 9'd1;
      overrun_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEADS: heads_q <= cfg_wdata_i[4:0];
          CFG_SPT:   spt_q   <= cfg_wdata_i;
          default:   heads_q <= heads_q;
        endcase
      end
      sector_q    <= sector_d;
      cyl_q       <= cyl_d;
      head_q      <= head_d;
      lba_q       <= lba_d;
      lba_sel_q   <= lba_sel_d;
      drive_q     <= drive_d;
      remaining_q <= remaining_d;
      overrun_q   <= overrun_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      prod1_q <= prod1_d;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // The count of sectors left never reaches zero.
  a_remaining_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q != 9'd0)
    else $error("sector count reached zero");

  // A step is only taken with more than one sector left.
  a_step_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> remaining_q > 9'd1)
    else $error("advance past the last sector");

endmodule

@@ sv/ata_chs_lba_address_sequencer.sv @@
// Top level of the ATA taskfile address sequencer.
// This block turns an ATA taskfile into a 28-bit logical block address and
// then walks it one sector at a time. A load transfer (operation 0) takes the
// sector count, sector number, cylinder and device/head bytes; bit 6 of
// device/head selects LBA mode, where the address is the packed fields,
// otherwise the address is (cylinder*heads+head)*sectors+sector-1 modulo
// 2^28 using the configured geometry. An advance transfer (operation 1) moves
// to the next sector, wrapping sector to 1, then head to 0 and bumping the
// cylinder, and increments the address; with one sector left it changes
// nothing and reports overrun. Every input transfer yields exactly one output
// transfer carrying the address, the updated taskfile bytes and the sectors
// left. A load passes through the two multiply steps of the address product,
// each of which is registered, and the done state before its result is
// offered; an advance passes through the advance state and the done state.
// The done state returns to idle once the output register is free. A new item
// is taken only when the sequencer is idle, but a finished
// result may wait in the output register while the next item is already being
// worked on. Geometry registers (index 0 heads per cylinder, index 1 sectors
// per track) are written through the cfg port and should only be changed
// while the block is idle.
module ata_chs_lba_address_sequencer
  import asq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  asq_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output asq_out_t   out_data_o
);

  asq_cmd_t    cmd;
  asq_status_t status;

  // The controller sequences load, multiply, advance and output steps.
  asq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds geometry, the current position and the output register.
  asq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/asq_address_checker.sv @@
// Checker for the ATA address sequencer: predicts each result transfer and compares it.
`timescale 1ns / 100ps

module asq_address_checker
  import asq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  asq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  asq_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  // Geometry as the block should see it.
  logic [4:0]  heads;
  logic [7:0]  spt;

  // Address walk state.
  logic [15:0] cur_sector;
  logic [15:0] cur_cyl;
  logic [7:0]  cur_head;
  logic [27:0] cur_lba;
  logic        lba_sel;
  logic [3:0]  drive;
  logic [8:0]  left;

  asq_out_t taskfile_results_q[$];
  int       fails;
  int       pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic asq_out_t step_sequencer(asq_in_t it);
    asq_out_t    r;
    logic [31:0] chs;
    logic        refused;
    refused = 1'b0;
    if (it.operation == OP_LOAD) begin
      cur_sector = {8'h00, it.sector_number_in};
      cur_cyl    = {it.cylinder_high_in, it.cylinder_low_in};
      cur_head   = {4'h0, it.device_head_in[3:0]};
      lba_sel    = it.device_head_in[DH_LBA_BIT];
      drive      = it.device_head_in[7:4];
      left       = (it.sector_count_in == 8'd0) ? COUNT_FULL : {1'b0, it.sector_count_in};
      if (lba_sel) begin
        cur_lba = {cur_head[3:0], cur_cyl, cur_sector[7:0]};
      end else begin
        // The product wraps at 32 bits and sector zero underflows, as in hardware.
        chs     = 32'(cur_cyl) * 32'(heads) + 32'(cur_head);
        chs     = chs * 32'(spt) + 32'(cur_sector) - 32'd1;
        cur_lba = chs[27:0];
      end
    end else if (left <= 9'd1) begin
      refused = 1'b1;
    end else begin
      left = left - 9'd1;
      if (cur_sector == {8'h00, spt}) begin
        cur_sector = 16'd1;
        cur_head   = cur_head + 8'd1;
        if (cur_head == {3'b000, heads}) begin
          cur_head = 8'd0;
          cur_cyl  = cur_cyl + 16'd1;
        end
      end else begin
        cur_sector = cur_sector + 16'd1;
      end
      cur_lba = cur_lba + 28'd1;
    end
    r.block_address = cur_lba;
    if (lba_sel) begin
      r.sector_number_out = cur_lba[7:0];
      r.cylinder_low_out  = cur_lba[15:8];
      r.cylinder_high_out = cur_lba[23:16];
      r.device_head_out   = {drive, cur_lba[27:24]};
    end else begin
      r.sector_number_out = cur_sector[7:0];
      r.cylinder_low_out  = cur_cyl[7:0];
      r.cylinder_high_out = cur_cyl[15:8];
      r.device_head_out   = {drive, cur_head[3:0]};
    end
    r.sectors_left = left;
    r.overrun      = refused;
    return r;
  endfunction

  function automatic void check_field(string name, logic [27:0] want, logic [27:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    asq_out_t want;
    if (!rst_ni) begin
      heads      = HEADS_RESET;
      spt        = SPT_RESET;
      cur_sector = '0;
      cur_cyl    = '0;
      cur_head   = '0;
      cur_lba    = '0;
      lba_sel    = 1'b0;
      drive      = '0;
      left       = 9'd1;
      fails      = 0;
      taskfile_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (taskfile_results_q.size() == 0) begin
          fails++;
          $display("%0t: result transfer with nothing pending, expected none actual %h",
                   $time, out_data_i);
        end else begin
          want = taskfile_results_q.pop_front();
          check_field("block_address", want.block_address, out_data_i.block_address);
          check_field("sector_number_out", 28'(want.sector_number_out),
                      28'(out_data_i.sector_number_out));
          check_field("cylinder_low_out", 28'(want.cylinder_low_out),
                      28'(out_data_i.cylinder_low_out));
          check_field("cylinder_high_out", 28'(want.cylinder_high_out),
                      28'(out_data_i.cylinder_high_out));
          check_field("device_head_out", 28'(want.device_head_out),
                      28'(out_data_i.device_head_out));
          check_field("sectors_left", 28'(want.sectors_left),
                      28'(out_data_i.sectors_left));
          check_field("overrun", 28'(want.overrun), 28'(out_data_i.overrun));
        end
      end
      // An item taken on this edge still uses the geometry from before any write here.
      if (in_valid_i && !in_stall_i) begin
        taskfile_results_q.push_back(step_sequencer(in_data_i));
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEADS) begin
          heads = cfg_wdata_i[4:0];
        end else begin
          spt = cfg_wdata_i;
        end
      end
    end
    pending = taskfile_results_q.size();
  end

endmodule

@@ tb/ata_chs_lba_address_sequencer_tb.sv @@
// Testbench top for the ATA address sequencer: stimulus, geometry phases and the verdict.
`timescale 1ns / 100ps

module ata_chs_lba_address_sequencer_tb;
  import asq_pkg::*;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = CFG_HEADS;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  asq_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  asq_out_t   out_data;

  int fail_count;
  int pending;

  // Transfer counters; the output side is counted on the clock so that the
  // stimulus sees it the same way the checker does.
  int sent = 0;
  int loads = 0;
  int advances = 0;
  int out_acc = 0;
  int settings = 0;

  // Geometry as last written, used only to steer the random taskfiles toward
  // the wrap points.
  logic [4:0] geo_heads = HEADS_RESET;
  logic [7:0] geo_spt = SPT_RESET;

  // calm switches off idling on both sides; hold_req asks the receiver for
  // one long hold-off.
  logic calm = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;

  ata_chs_lba_address_sequencer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  asq_address_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      out_acc <= out_acc + 1;
    end
  end

  // Receiver. Outside a hold-off it stalls at random; a hold-off keeps stall
  // high long enough for the sequencer and its output register to fill up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 38);
    end
  end

  // Offers one item and returns at the edge where its transfer happened. An
  // idle gap, when chosen, starts at the edge of the previous transfer.
  task automatic send(asq_in_t it);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
    if (it.operation == OP_LOAD) begin
      loads++;
    end else begin
      advances++;
    end
  endtask

  task automatic load(logic [7:0] cnt, logic [7:0] sn, logic [7:0] cl, logic [7:0] ch,
                      logic [7:0] dh);
    asq_in_t it;
    it.operation        = OP_LOAD;
    it.sector_count_in  = cnt;
    it.sector_number_in = sn;
    it.cylinder_low_in  = cl;
    it.cylinder_high_in = ch;
    it.device_head_in   = dh;
    send(it);
  endtask

  // The taskfile bytes of an advance are ignored, so they carry random values.
  task automatic advance();
    asq_in_t it;
    it = asq_in_t'(41'({$urandom, $urandom}));
    it.operation = OP_ADVANCE;
    send(it);
  endtask

  // Lowers valid, waits until every result transfer has come back and then lets
  // the sequencer settle in its idle state.
  task automatic drain();
    in_valid <= 1'b0;
    while (out_acc != sent) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes both geometry registers back to back while the block is idle.
  task automatic set_geometry(logic [7:0] heads_val, logic [7:0] spt_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HEADS;
    cfg_wdata <= heads_val;
    @(posedge clk);
    cfg_idx   <= CFG_SPT;
    cfg_wdata <= spt_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    geo_heads = heads_val[4:0];
    geo_spt   = spt_val;
    settings++;
  endtask

  // Most sequences are a load followed by a run of advances, with the taskfile
  // biased toward the sector, head, cylinder and address wrap points so that
  // the walk crosses them. A tenth of the time a lone item is sent as noise.
  task automatic random_sequence();
    logic [7:0]  cnt;
    logic [7:0]  sn;
    logic [15:0] cyl;
    logic [3:0]  hd;
    logic [7:0]  dh;
    int          r;
    int          k;
    bit          long_run;
    long_run = 1'b0;
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) == 1) begin
        advance();
      end else begin
        load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      return;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      cnt = 8'($urandom_range(1, 6));
    end else if (r < 56) begin
      cnt = 8'd0;
      long_run = 1'b1;
    end else begin
      cnt = 8'($urandom);
    end
    r = $urandom_range(99);
    if (r < 35) begin
      sn = geo_spt - 8'($urandom_range(0, 2));
    end else if (r < 45) begin
      sn = 8'd0;
    end else begin
      sn = 8'($urandom);
    end
    if ($urandom_range(99) < 40) begin
      hd = geo_heads[3:0] - 4'($urandom_range(1, 2));
    end else begin
      hd = 4'($urandom);
    end
    if ($urandom_range(99) < 20) begin
      cyl = 16'hFFFF - 16'($urandom_range(0, 1));
    end else begin
      cyl = 16'($urandom);
    end
    dh = {4'($urandom), hd};
    // An all-ones LBA taskfile makes the address wrap on the first advance.
    if (dh[DH_LBA_BIT] && $urandom_range(9) == 0) begin
      sn  = 8'hFF;
      cyl = 16'hFFFF;
      dh[3:0] = 4'hF;
    end
    load(cnt, sn, cyl[7:0], cyl[15:8], dh);
    k = long_run ? 257 : $urandom_range(0, 10);
    repeat (k) advance();
  endtask

  initial begin
    logic [7:0] phase_heads[8];
    logic [7:0] phase_spt[8];
    int         start;
    phase_heads = '{8'h10, 8'hE1, 8'hFF, 8'h00, 8'h01, 8'h05, 8'h02, 8'h10};
    phase_spt   = '{8'd63, 8'd1, 8'd255, 8'd0, 8'd255, 8'd17, 8'd63, 8'd3};
    // Randomize the last setting but one so the seed picks a fresh geometry.
    phase_heads[6] = 8'($urandom);
    phase_spt[6]   = 8'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset geometry of 16 heads and 63 sectors.
    // A CHS sector of zero underflows to the top address, then an advance
    // with one sector left is refused.
    load(8'd1, 8'h00, 8'h00, 8'h00, 8'hA0);
    advance();
    // An all-ones LBA taskfile wraps to address zero, then runs out.
    load(8'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    advance();
    advance();
    // A count of zero means 256 sectors; the start sits on the last sector,
    // last head and last cylinder, so the first advance wraps all three.
    load(8'd0, 8'd63, 8'hFF, 8'hFF, 8'h0F);
    advance();
    advance();
    // A sector beyond the geometry just keeps counting.
    load(8'd255, 8'd200, 8'd12, 8'd0, 8'h13);
    advance();
    advance();
    // LBA zero with a single sector.
    load(8'd1, 8'h00, 8'h00, 8'h00, 8'h40);
    advance();

    // Smallest geometry: every advance bumps the cylinder. The spare upper
    // bits of the heads write are set and must be dropped.
    set_geometry(8'hE1, 8'd1);
    load(8'd4, 8'd1, 8'h00, 8'h00, 8'h00);
    repeat (4) advance();

    // Zero geometry is used as written.
    set_geometry(8'h00, 8'd0);
    load(8'd3, 8'd0, 8'h00, 8'h00, 8'h0E);
    advance();
    advance();

    // Random phases over several geometries.
    for (int p = 0; p < 8; p++) begin
      set_geometry(phase_heads[p], phase_spt[p]);
      if (p == 1) begin
        hold_req <= hold_req + 1;
      end
      if (p == 2) begin
        calm <= 1'b1;
      end
      if (p == 3) begin
        calm <= 1'b0;
      end
      start = sent;
      while (sent - start < 200) begin
        random_sequence();
        // In phase 4, at 100 to 111 items sent, each sequence ends by waiting for every result.
        if (p == 4 && sent - start >= 100 && sent - start < 112) begin
          drain();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Summary: %0d loads and %0d advances transferred under %0d geometry settings,",
             loads, advances, settings);
    $display("with a long output hold-off, a full drain and an idle-free stretch.");
    if (pending != 0) begin
      $display("%0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("ata_chs_lba_address_sequencer_tb passed");
    end else begin
      $display("ata_chs_lba_address_sequencer_tb failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("ata_chs_lba_address_sequencer_tb failed");
    $finish;
  end

endmodule
